// File: sv/best_fit_heap_allocator_defines.svh
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Checks that a condition in one cycle implies another in the same cycle.
`define BFHA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define BFHA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: sv/bfha_pkg.sv
package bfha_pkg;

   localparam int ADDR_W = 48;
   localparam int SIZE_W = 32;
   localparam int ALIGN_BYTES = 16;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REALLOC = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   localparam logic REG_HEAP_BASE = 1'b0;
   localparam logic REG_HEAP_SIZE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              is_free;
      logic [SIZE_W-1:0] offset;
      logic [SIZE_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic init;
   } ring_ctl_type;

endpackage

// File: sv/bfha_intf.sv
interface bfha_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [47:0] data_address;
   logic [31:0] request_size;

   modport source (output valid, kind, data_address, request_size, input ready);
   modport sink (input valid, kind, data_address, request_size, output ready);
endinterface

interface bfha_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] result_address;
   logic [1:0]  status;
   logic        move_needed;
   logic [31:0] copy_length;
   logic [31:0] bytes_used;
   logic [31:0] bytes_total;

   modport source (output valid, result_address, status, move_needed, copy_length,
                   bytes_used, bytes_total, input ready);
   modport sink (input valid, result_address, status, move_needed, copy_length,
                 bytes_used, bytes_total, output ready);
endinterface

// File: sv/bfha_cell.sv
module bfha_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bfha_pkg::ring_ctl_type ctl,
   input  bfha_pkg::entry_type    init_entry,
   input  bfha_pkg::entry_type    next_entry,
   output bfha_pkg::entry_type    entry
);

   logic                          valid_ff;
   logic                          is_free_ff;
   logic [bfha_pkg::SIZE_W-1:0]   offset_ff;
   logic [bfha_pkg::SIZE_W-1:0]   length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.init) begin
         valid_ff <= init_entry.valid;
      end else if (ctl.shift) begin
         valid_ff <= next_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         is_free_ff <= init_entry.is_free;
         offset_ff  <= init_entry.offset;
         length_ff  <= init_entry.length;
      end else if (ctl.shift) begin
         is_free_ff <= next_entry.is_free;
         offset_ff  <= next_entry.offset;
         length_ff  <= next_entry.length;
      end
   end

   assign entry.valid   = valid_ff;
   assign entry.is_free = is_free_ff;
   assign entry.offset  = offset_ff;
   assign entry.length  = length_ff;

endmodule

// File: sv/bfha_ctrl.sv
module bfha_ctrl #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 80
) (
   input  logic                   clock,
   input  logic                   reset,
   bfha_req_if.sink               req,
   bfha_rsp_if.source             rsp,
   input  logic [47:0]            heap_base,
   input  logic [31:0]            heap_size,
   input  logic                   cfg_wr,
   input  bfha_pkg::entry_type    head,
   output bfha_pkg::entry_type    tail,
   output bfha_pkg::entry_type    init_entry,
   output bfha_pkg::ring_ctl_type ring_ctl
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DECIDE  = 3'd2;
   localparam logic [2:0] S_NEIGH   = 3'd3;
   localparam logic [2:0] S_APPLY   = 3'd4;
   localparam logic [2:0] S_RELEASE = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff;
   logic [1:0]       op_ff, op_in;
   logic [47:0]      addr_ff, addr_in;
   logic [32:0]      need_ff, need_in;

   logic             b_found_ff, b_found_in, b_free_ff, b_free_in;
   logic [IDX_W-1:0] b_idx_ff, b_idx_in;
   logic [31:0]      b_off_ff, b_off_in, b_len_ff, b_len_in;
   logic             best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_off_ff, best_off_in, best_len_ff, best_len_in;
   logic             slot_found_ff, slot_found_in;
   logic [IDX_W-1:0] slot_idx_ff, slot_idx_in;
   logic             n_found_ff, n_found_in, p_found_ff, p_found_in;
   logic [IDX_W-1:0] n_idx_ff, n_idx_in, p_idx_ff, p_idx_in;
   logic [31:0]      n_len_ff, n_len_in, p_len_ff, p_len_in;

   logic [IDX_W-1:0] t_idx_ff, t_idx_in, as_idx_ff, as_idx_in, inv_idx_ff, inv_idx_in;
   logic [31:0]      t_off_ff, t_off_in, base_ff, base_in, sub_ff, sub_in;
   logic             as_ok_ff, as_ok_in, inv_en_ff, inv_en_in;
   logic             grow_chk_ff, grow_chk_in, rel_after_ff, rel_after_in;

   logic [47:0]      res_ff, res_in;
   logic [1:0]       status_ff, status_in;
   logic             move_ff, move_in;
   logic [31:0]      copy_ff, copy_in;
   logic [31:0]      used_ff, used_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [47:0]      o_addr_ff, o_addr_in;
   logic [1:0]       o_status_ff, o_status_in;
   logic             o_move_ff, o_move_in;
   logic [31:0]      o_copy_ff, o_copy_in, o_used_ff, o_used_in, o_total_ff, o_total_in;

   logic             last;
   logic [47:0]      head_addr, best_addr;
   logic [31:0]      total;
   logic [33:0]      b_end, head_end;
   logic             split;
   logic [31:0]      final_len, new_len;
   logic [32:0]      comb_len, req_need;
   logic [1:0]       req_kind;

   assign last      = (idx_ff == LAST_IDX);
   assign head_addr = heap_base + 48'(head.offset) + 48'(HEADER_BYTES);
   assign best_addr = heap_base + 48'(best_off_ff) + 48'(HEADER_BYTES);
   assign total     = (heap_size >= 32'(HEADER_BYTES)) ? heap_size - 32'(HEADER_BYTES) : '0;
   assign b_end     = 34'(b_off_ff) + 34'(HEADER_BYTES) + 34'(b_len_ff);
   assign head_end  = 34'(head.offset) + 34'(HEADER_BYTES) + 34'(head.length);
   assign split     = as_ok_ff && (34'(base_ff) >=
                      34'(need_ff) + 34'(2 * HEADER_BYTES + bfha_pkg::ALIGN_BYTES));
   assign final_len = split ? need_ff[31:0] : base_ff;
   assign comb_len  = 33'(b_len_ff) + 33'(HEADER_BYTES) + 33'(n_len_ff);
   assign new_len   = b_len_ff + (n_found_ff ? 32'(HEADER_BYTES) + n_len_ff : '0);
   assign req_need  = (33'(req.request_size) + 33'(bfha_pkg::ALIGN_BYTES - 1)) &
                      ~33'(bfha_pkg::ALIGN_BYTES - 1);

   always_comb begin
      req_kind = req.kind;
      if (req_kind == bfha_pkg::KIND_REALLOC && req.data_address == '0) begin
         req_kind = bfha_pkg::KIND_ALLOC;
      end
      if (req_kind == bfha_pkg::KIND_REALLOC && req.request_size == '0) begin
         req_kind = bfha_pkg::KIND_FREE;
      end
   end

   assign req.ready      = (state_ff == S_IDLE) && !pend_ff;
   assign ring_ctl.init  = pend_ff;
   assign ring_ctl.shift = (state_ff == S_SCAN) || (state_ff == S_NEIGH) ||
                           (state_ff == S_APPLY) || (state_ff == S_RELEASE);

   assign init_entry.valid   = 1'b1;
   assign init_entry.is_free = 1'b1;
   assign init_entry.offset  = '0;
   assign init_entry.length  = total;

   always_comb begin
      state_in = state_ff;  idx_in = idx_ff;  op_in = op_ff;
      addr_in = addr_ff;  need_in = need_ff;
      b_found_in = b_found_ff;  b_free_in = b_free_ff;  b_idx_in = b_idx_ff;
      b_off_in = b_off_ff;  b_len_in = b_len_ff;
      best_found_in = best_found_ff;  best_idx_in = best_idx_ff;
      best_off_in = best_off_ff;  best_len_in = best_len_ff;
      slot_found_in = slot_found_ff;  slot_idx_in = slot_idx_ff;
      n_found_in = n_found_ff;  n_idx_in = n_idx_ff;  n_len_in = n_len_ff;
      p_found_in = p_found_ff;  p_idx_in = p_idx_ff;  p_len_in = p_len_ff;
      t_idx_in = t_idx_ff;  t_off_in = t_off_ff;  base_in = base_ff;  sub_in = sub_ff;
      as_ok_in = as_ok_ff;  as_idx_in = as_idx_ff;
      inv_en_in = inv_en_ff;  inv_idx_in = inv_idx_ff;
      grow_chk_in = grow_chk_ff;  rel_after_in = rel_after_ff;
      res_in = res_ff;  status_in = status_ff;  move_in = move_ff;  copy_in = copy_ff;
      used_in = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      o_addr_in = o_addr_ff;  o_status_in = o_status_ff;  o_move_in = o_move_ff;
      o_copy_in = o_copy_ff;  o_used_in = o_used_ff;  o_total_in = o_total_ff;
      tail = head;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req_kind;
               addr_in = req.data_address;
               need_in = req_need;
               idx_in = '0;
               res_in = '0;
               status_in = bfha_pkg::ST_DONE;
               move_in = 1'b0;
               copy_in = '0;
               b_found_in = 1'b0;
               best_found_in = 1'b0;
               slot_found_in = 1'b0;
               if (req_kind == bfha_pkg::KIND_ALLOC && req.request_size == '0) begin
                  status_in = bfha_pkg::ST_NOFIT;
                  state_in = S_OUT;
               end else if (req_kind == bfha_pkg::KIND_FREE && req.data_address == '0) begin
                  status_in = bfha_pkg::ST_IGNORED;
                  state_in = S_OUT;
               end else if (req_kind != bfha_pkg::KIND_ALLOC &&
                            req_kind != bfha_pkg::KIND_FREE &&
                            req_kind != bfha_pkg::KIND_REALLOC) begin
                  status_in = bfha_pkg::ST_IGNORED;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!b_found_ff && head.valid && head_addr == addr_ff) begin
               b_found_in = 1'b1;
               b_idx_in = idx_ff;
               b_off_in = head.offset;
               b_len_in = head.length;
               b_free_in = head.is_free;
            end
            if (head.valid && head.is_free && 33'(head.length) >= need_ff &&
                (!best_found_ff || head.length < best_len_ff ||
                 (head.length == best_len_ff && head.offset < best_off_ff))) begin
               best_found_in = 1'b1;
               best_idx_in = idx_ff;
               best_off_in = head.offset;
               best_len_in = head.length;
            end
            if (!slot_found_ff && !head.valid) begin
               slot_found_in = 1'b1;
               slot_idx_in = idx_ff;
            end
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) begin
               grow_chk_in = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in = '0;
            rel_after_in = 1'b0;
            inv_en_in = 1'b0;
            if (grow_chk_ff) begin
               if (n_found_ff && comb_len >= need_ff) begin
                  t_idx_in = b_idx_ff;  t_off_in = b_off_ff;
                  base_in = comb_len[31:0];  sub_in = b_len_ff;
                  as_ok_in = 1'b1;  as_idx_in = n_idx_ff;
                  inv_en_in = 1'b1;  inv_idx_in = n_idx_ff;
                  res_in = addr_ff;
                  state_in = S_APPLY;
               end else if (!best_found_ff) begin
                  status_in = bfha_pkg::ST_NOFIT;
                  state_in = S_OUT;
               end else begin
                  t_idx_in = best_idx_ff;  t_off_in = best_off_ff;
                  base_in = best_len_ff;  sub_in = '0;
                  as_ok_in = slot_found_ff;  as_idx_in = slot_idx_ff;
                  res_in = best_addr;
                  move_in = 1'b1;
                  copy_in = b_len_ff;
                  rel_after_in = 1'b1;
                  state_in = S_APPLY;
               end
            end else if (op_ff == bfha_pkg::KIND_ALLOC) begin
               if (!best_found_ff) begin
                  status_in = bfha_pkg::ST_NOFIT;
                  state_in = S_OUT;
               end else begin
                  t_idx_in = best_idx_ff;  t_off_in = best_off_ff;
                  base_in = best_len_ff;  sub_in = '0;
                  as_ok_in = slot_found_ff;  as_idx_in = slot_idx_ff;
                  res_in = best_addr;
                  state_in = S_APPLY;
               end
            end else if (!b_found_ff || b_free_ff) begin
               status_in = bfha_pkg::ST_IGNORED;
               state_in = S_OUT;
            end else if (op_ff == bfha_pkg::KIND_REALLOC && 33'(b_len_ff) >= need_ff) begin
               t_idx_in = b_idx_ff;  t_off_in = b_off_ff;
               base_in = b_len_ff;  sub_in = b_len_ff;
               as_ok_in = slot_found_ff;  as_idx_in = slot_idx_ff;
               res_in = addr_ff;
               state_in = S_APPLY;
            end else begin
               grow_chk_in = (op_ff == bfha_pkg::KIND_REALLOC);
               state_in = S_NEIGH;
            end
         end
         S_NEIGH: begin
            n_found_in = (idx_ff == '0) ? 1'b0 : n_found_ff;
            p_found_in = (idx_ff == '0) ? 1'b0 : p_found_ff;
            if (head.valid && head.is_free && 34'(head.offset) == b_end) begin
               n_found_in = 1'b1;
               n_idx_in = idx_ff;
               n_len_in = head.length;
            end
            if (head.valid && head.is_free && head_end == 34'(b_off_ff)) begin
               p_found_in = 1'b1;
               p_idx_in = idx_ff;
               p_len_in = head.length;
            end
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) begin
               state_in = grow_chk_ff ? S_DECIDE : S_RELEASE;
            end
         end
         S_APPLY: begin
            if (idx_ff == t_idx_ff) begin
               tail.is_free = 1'b0;
               tail.length = final_len;
            end else if (split && idx_ff == as_idx_ff) begin
               tail.valid = 1'b1;
               tail.is_free = 1'b1;
               tail.offset = t_off_ff + 32'(HEADER_BYTES) + need_ff[31:0];
               tail.length = base_ff - need_ff[31:0] - 32'(HEADER_BYTES);
            end else if (inv_en_ff && idx_ff == inv_idx_ff) begin
               tail.valid = 1'b0;
            end
            if (idx_ff == '0) begin
               used_in = used_ff - sub_ff + final_len;
            end
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) begin
               grow_chk_in = 1'b0;
               state_in = rel_after_ff ? S_NEIGH : S_OUT;
            end
         end
         S_RELEASE: begin
            if (n_found_ff && idx_ff == n_idx_ff) begin
               tail.valid = 1'b0;
            end else if (idx_ff == b_idx_ff) begin
               if (p_found_ff) begin
                  tail.valid = 1'b0;
               end else begin
                  tail.is_free = 1'b1;
                  tail.length = new_len;
               end
            end else if (p_found_ff && idx_ff == p_idx_ff) begin
               tail.length = p_len_ff + 32'(HEADER_BYTES) + new_len;
            end
            if (idx_ff == '0) begin
               used_in = used_ff - b_len_ff;
            end
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               o_addr_in = res_ff;
               o_status_in = status_ff;
               o_move_in = move_ff;
               o_copy_in = copy_ff;
               o_used_in = used_ff;
               o_total_in = total;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         pend_ff <= 1'b1;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         pend_ff <= cfg_wr;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  addr_ff <= addr_in;  need_ff <= need_in;
      b_found_ff <= b_found_in;  b_free_ff <= b_free_in;  b_idx_ff <= b_idx_in;
      b_off_ff <= b_off_in;  b_len_ff <= b_len_in;
      best_found_ff <= best_found_in;  best_idx_ff <= best_idx_in;
      best_off_ff <= best_off_in;  best_len_ff <= best_len_in;
      slot_found_ff <= slot_found_in;  slot_idx_ff <= slot_idx_in;
      n_found_ff <= n_found_in;  n_idx_ff <= n_idx_in;  n_len_ff <= n_len_in;
      p_found_ff <= p_found_in;  p_idx_ff <= p_idx_in;  p_len_ff <= p_len_in;
      t_idx_ff <= t_idx_in;  t_off_ff <= t_off_in;  base_ff <= base_in;  sub_ff <= sub_in;
      as_ok_ff <= as_ok_in;  as_idx_ff <= as_idx_in;
      inv_en_ff <= inv_en_in;  inv_idx_ff <= inv_idx_in;
      grow_chk_ff <= grow_chk_in;  rel_after_ff <= rel_after_in;
      res_ff <= res_in;  status_ff <= status_in;  move_ff <= move_in;  copy_ff <= copy_in;
      o_addr_ff <= o_addr_in;  o_status_ff <= o_status_in;  o_move_ff <= o_move_in;
      o_copy_ff <= o_copy_in;  o_used_ff <= o_used_in;  o_total_ff <= o_total_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_address = o_addr_ff;
   assign rsp.status         = o_status_ff;
   assign rsp.move_needed    = o_move_ff;
   assign rsp.copy_length    = o_copy_ff;
   assign rsp.bytes_used     = o_used_ff;
   assign rsp.bytes_total    = o_total_ff;

endmodule

// File: sv/best_fit_heap_allocator.sv
// Channel   Direction  Contents
// req       in         kind, data_address, request_size
// rsp       out        result_address, status, move_needed, copy_length, bytes_used, bytes_total
// apb       in/out     heap_base at 0x0, heap_size at 0x8
//
// The block table circulates through a ring of MAX_BLOCKS cells, one entry per cycle while a pass is running.
// A transaction makes zero to five passes over the ring of MAX_BLOCKS cells: a request
// rejected outright makes none, an allocate two, a free three, a reallocate that grows in
// place three and a moving reallocate five.
// After reset, and in the cycle after a configuration write, the table is rebuilt while the
// input is held off.
// A result waits in the output register while the next transaction is accepted; a result
// that is still waiting holds the next one in its output step and so stalls the input.
module best_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 80
) (
   input  logic        clock,
   input  logic        reset,
   bfha_req_if.sink    req,
   bfha_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [47:0]            heap_base_ff;
   logic [31:0]            heap_size_ff;
   logic                   cfg_wr;
   bfha_pkg::entry_type    cells [MAX_BLOCKS];
   bfha_pkg::entry_type    tail;
   bfha_pkg::entry_type    init_entry;
   bfha_pkg::ring_ctl_type ring_ctl;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[3] == bfha_pkg::REG_HEAP_SIZE) ? {32'd0, heap_size_ff}
                                                         : {16'd0, heap_base_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= 32'd65536;
      end else if (cfg_wr) begin
         if (paddr[3] == bfha_pkg::REG_HEAP_BASE) begin
            heap_base_ff <= pwdata[47:0];
         end else begin
            heap_size_ff <= pwdata[31:0];
         end
      end
   end

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      bfha_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ring_ctl),
         .init_entry ((i == 0) ? init_entry : '0),
         .next_entry ((i == MAX_BLOCKS - 1) ? tail : cells[(i + 1) % MAX_BLOCKS]),
         .entry      (cells[i])
      );
   end

   bfha_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .heap_base  (heap_base_ff),
      .heap_size  (heap_size_ff),
      .cfg_wr     (cfg_wr),
      .head       (cells[0]),
      .tail       (tail),
      .init_entry (init_entry),
      .ring_ctl   (ring_ctl)
   );

endmodule

// File: sv/bfha_checker.sv
`include "best_fit_heap_allocator_defines.svh"

module bfha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] result_address,
   input logic [1:0]  status,
   input logic        move_needed,
   input logic [31:0] copy_length,
   input logic [31:0] bytes_used,
   input logic [31:0] bytes_total
);

   `BFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(result_address) && $stable(status))

   `BFHA_ASSERT_SAME(a_used_bound, clock, reset, rsp_valid, bytes_used <= bytes_total)

   `BFHA_ASSERT_SAME(a_move_done, clock, reset, rsp_valid && move_needed,
      status == bfha_pkg::ST_DONE && result_address != '0)

   `BFHA_ASSERT_SAME(a_fail_clean, clock, reset, rsp_valid && status != bfha_pkg::ST_DONE,
      !move_needed && copy_length == '0 && result_address == '0)

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .result_address (rsp.result_address),
   .status         (rsp.status),
   .move_needed    (rsp.move_needed),
   .copy_length    (rsp.copy_length),
   .bytes_used     (rsp.bytes_used),
   .bytes_total    (rsp.bytes_total)
);

// File: dv/tb_best_fit_heap_allocator.sv
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator;

   localparam int NUM_ENTRIES = 64;
   localparam int HDR = 80;
   localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [47:0] address;
      logic [1:0]  status;
      logic        move_needed;
      logic [31:0] copy_length;
      logic [31:0] bytes_used;
      logic [31:0] bytes_total;
   } heap_result_type;

   class heap_scoreboard;
      longint unsigned base;
      longint unsigned size;
      longint unsigned offset[NUM_ENTRIES];
      longint unsigned length[NUM_ENTRIES];
      bit              is_free[NUM_ENTRIES];
      bit              in_use[NUM_ENTRIES];
      bit [31:0]       used;
      heap_result_type pending[$];
      int              errors;

      function new();
         base = 0;
         size = 65536;
         errors = 0;
         clear_table();
      endfunction

      function longint unsigned usable();
         return (size >= HDR) ? size - HDR : 0;
      endfunction

      function void clear_table();
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            offset[i] = 0;
            length[i] = 0;
            is_free[i] = 0;
            in_use[i] = 0;
         end
         length[0] = usable();
         is_free[0] = 1;
         in_use[0] = 1;
         used = 0;
      endfunction

      function void configure(bit idx, longint unsigned value);
         if (idx == bfha_pkg::REG_HEAP_BASE) base = value & MASK48;
         else size = value & 64'hFFFF_FFFF;
         clear_table();
      endfunction

      function longint unsigned pointer_of(int i);
         return (base + offset[i] + HDR) & MASK48;
      endfunction

      function longint unsigned end_of(int i);
         return offset[i] + HDR + length[i];
      endfunction

      function int by_pointer(longint unsigned a);
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (in_use[i] && pointer_of(i) == a) return i;
         return -1;
      endfunction

      function int starting_at(longint unsigned o);
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (in_use[i] && offset[i] == o) return i;
         return -1;
      endfunction

      function int ending_at(longint unsigned o);
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (in_use[i] && end_of(i) == o) return i;
         return -1;
      endfunction

      function void split(int i, longint unsigned need);
         int s;
         if (length[i] < need + 2 * HDR + bfha_pkg::ALIGN_BYTES) return;
         s = -1;
         for (int k = 0; k < NUM_ENTRIES; k++)
            if (!in_use[k] && s < 0) s = k;
         if (s < 0) return;
         in_use[s] = 1;
         is_free[s] = 1;
         offset[s] = offset[i] + HDR + need;
         length[s] = length[i] - need - HDR;
         length[i] = need;
      endfunction

      function int grab_best(longint unsigned need);
         int b;
         b = -1;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!in_use[i] || !is_free[i] || length[i] < need) continue;
            if (b < 0 || length[i] < length[b] ||
                (length[i] == length[b] && offset[i] < offset[b])) b = i;
         end
         if (b < 0) return -1;
         split(b, need);
         is_free[b] = 0;
         used = used + length[b][31:0];
         return b;
      endfunction

      function void give_back(int i);
         int n, p;
         used = used - length[i][31:0];
         is_free[i] = 1;
         n = starting_at(end_of(i));
         if (n >= 0 && n != i && is_free[n]) begin
            length[i] += HDR + length[n];
            in_use[n] = 0;
         end
         p = ending_at(offset[i]);
         if (p >= 0 && p != i && is_free[p]) begin
            length[p] += HDR + length[i];
            in_use[i] = 0;
         end
      endfunction

      function void live_pointers(ref logic [47:0] ptrs[$]);
         ptrs.delete();
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (in_use[i] && !is_free[i]) ptrs.push_back(48'(pointer_of(i)));
      endfunction

      function void note_request(logic [1:0] kind_in, logic [47:0] addr_in,
                                 logic [31:0] size_in);
         heap_result_type r;
         logic [1:0] kind;
         longint unsigned addr, req, need, old, comb;
         int b, n, nb;
         kind = kind_in;
         addr = 64'(addr_in);
         req = 64'(size_in);
         need = (req + bfha_pkg::ALIGN_BYTES - 1) / bfha_pkg::ALIGN_BYTES *
                bfha_pkg::ALIGN_BYTES;
         r.address = 0;
         r.status = bfha_pkg::ST_DONE;
         r.move_needed = 0;
         r.copy_length = 0;
         if (kind == bfha_pkg::KIND_REALLOC && addr == 0) kind = bfha_pkg::KIND_ALLOC;
         if (kind == bfha_pkg::KIND_REALLOC && req == 0) kind = bfha_pkg::KIND_FREE;
         if (kind == bfha_pkg::KIND_ALLOC) begin
            if (req == 0) r.status = bfha_pkg::ST_NOFIT;
            else begin
               b = grab_best(need);
               if (b < 0) r.status = bfha_pkg::ST_NOFIT;
               else r.address = 48'(pointer_of(b));
            end
         end else if (kind == bfha_pkg::KIND_FREE) begin
            b = (addr != 0) ? by_pointer(addr) : -1;
            if (b < 0 || is_free[b]) r.status = bfha_pkg::ST_IGNORED;
            else give_back(b);
         end else if (kind == bfha_pkg::KIND_REALLOC) begin
            b = by_pointer(addr);
            if (b < 0 || is_free[b]) r.status = bfha_pkg::ST_IGNORED;
            else if (length[b] >= need) begin
               old = length[b];
               split(b, need);
               used = used - 32'(old - length[b]);
               r.address = 48'(addr);
            end else begin
               n = starting_at(end_of(b));
               comb = 0;
               if (n >= 0 && n != b && is_free[n]) comb = length[b] + HDR + length[n];
               if (comb != 0 && comb >= need) begin
                  in_use[n] = 0;
                  used = used - length[b][31:0];
                  length[b] = comb;
                  split(b, need);
                  used = used + length[b][31:0];
                  r.address = 48'(addr);
               end else begin
                  nb = grab_best(need);
                  if (nb < 0) r.status = bfha_pkg::ST_NOFIT;
                  else begin
                     r.address = 48'(pointer_of(nb));
                     r.move_needed = 1;
                     r.copy_length = length[b][31:0];
                     give_back(b);
                  end
               end
            end
         end else begin
            r.status = bfha_pkg::ST_IGNORED;
         end
         r.bytes_used = used;
         r.bytes_total = 32'(usable());
         pending.push_back(r);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
         errors++;
      endtask

      task check_result(heap_result_type got);
         heap_result_type want;
         if (pending.size() == 0) begin
            $display("[%0t] unexpected result transaction", $realtime);
            errors++;
         end else begin
            want = pending.pop_front();
            if (got.address !== want.address) report("result_address", got.address,
                                                     want.address);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.move_needed !== want.move_needed)
               report("move_needed", got.move_needed, want.move_needed);
            if (got.copy_length !== want.copy_length)
               report("copy_length", got.copy_length, want.copy_length);
            if (got.bytes_used !== want.bytes_used)
               report("bytes_used", got.bytes_used, want.bytes_used);
            if (got.bytes_total !== want.bytes_total)
               report("bytes_total", got.bytes_total, want.bytes_total);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   bfha_req_if req_if();
   bfha_rsp_if rsp_if();

   best_fit_heap_allocator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   heap_scoreboard heap_sb = new();
   logic [47:0] live[$];
   int sent_count = 0;
   bit steady = 0;

   initial clock = 0;
   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   task send_request(logic [1:0] kind, logic [47:0] addr, logic [31:0] size);
      req_if.valid <= 1;
      req_if.kind <= kind;
      req_if.data_address <= addr;
      req_if.request_size <= size;
      do @(posedge clock); while (!req_if.ready);
      heap_sb.note_request(kind, addr, size);
      heap_sb.live_pointers(live);
      sent_count++;
      if (!steady && $urandom_range(99) < 13) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task write_register(bit idx, longint unsigned value);
      req_if.valid <= 0;
      while (heap_sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= idx ? 4'h8 : 4'h0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      heap_sb.configure(idx, value);
      heap_sb.live_pointers(live);
   endtask

   function logic [47:0] pick_pointer();
      int r;
      r = $urandom_range(99);
      if (live.size() != 0 && r < 85) return live[$urandom_range(live.size() - 1)];
      if (r < 90) return 0;
      if (r < 95 && live.size() != 0) return live[0] + 48'd16;
      return 48'({$urandom, $urandom});
   endfunction

   function logic [31:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 300);
      if (r < 90) return $urandom_range(1, 8000);
      if (r < 95) return 0;
      return $urandom;
   endfunction

   task random_items(int count, int free_pct);
      int r;
      for (int n = 0; n < count; n++) begin
         steady = (sent_count >= 120 && sent_count < 220);
         r = $urandom_range(99);
         if (r < 3) send_request(KIND_UNUSED, 48'({$urandom, $urandom}), $urandom);
         else if (r < 3 + free_pct)
            send_request(bfha_pkg::KIND_FREE, pick_pointer(), $urandom);
         else if (r < 15 + free_pct)
            send_request(bfha_pkg::KIND_REALLOC, pick_pointer(), pick_size());
         else send_request(bfha_pkg::KIND_ALLOC, 48'({$urandom, $urandom}), pick_size());
      end
      steady = 0;
   endtask

   initial begin
      heap_result_type got;
      int hold;
      rsp_if.ready <= 0;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.address = rsp_if.result_address;
            got.status = rsp_if.status;
            got.move_needed = rsp_if.move_needed;
            got.copy_length = rsp_if.copy_length;
            got.bytes_used = rsp_if.bytes_used;
            got.bytes_total = rsp_if.bytes_total;
            heap_sb.check_result(got);
         end
         if (sent_count == 300 && hold == 0) hold = 1500;
         if (hold > 1) begin
            hold--;
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 13);
         end
      end
   end

   initial begin
      logic [47:0] p;
      reset <= 1;
      req_if.valid <= 0;
      req_if.kind <= bfha_pkg::KIND_ALLOC;
      req_if.data_address <= 0;
      req_if.request_size <= 0;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      csr_paddr <= 0;
      csr_pwdata <= 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_request(bfha_pkg::KIND_ALLOC, 0, 0);
      send_request(bfha_pkg::KIND_ALLOC, 0, 32'hFFFF_FFFF);
      send_request(bfha_pkg::KIND_ALLOC, 0, 1);
      send_request(bfha_pkg::KIND_ALLOC, 0, 100);
      send_request(bfha_pkg::KIND_ALLOC, 0, 200);
      send_request(bfha_pkg::KIND_FREE, 0, 0);
      send_request(bfha_pkg::KIND_FREE, 48'hFFFF_FFFF_FFFF, 0);
      p = live[1];
      send_request(bfha_pkg::KIND_FREE, p, 0);
      send_request(bfha_pkg::KIND_FREE, p, 0);
      send_request(bfha_pkg::KIND_REALLOC, 0, 64);
      send_request(bfha_pkg::KIND_REALLOC, p, 64);
      send_request(bfha_pkg::KIND_REALLOC, live[0], 500);
      send_request(bfha_pkg::KIND_REALLOC, live[0], 16);
      send_request(bfha_pkg::KIND_REALLOC, live[0], 2000);
      send_request(bfha_pkg::KIND_REALLOC, live[live.size() - 1], 32'hFFFF_0000);
      send_request(bfha_pkg::KIND_REALLOC, live[0], 0);
      send_request(KIND_UNUSED, 0, 0);
      random_items(150, 22);

      write_register(bfha_pkg::REG_HEAP_BASE, 64'h1234_5678_9AB0);
      write_register(bfha_pkg::REG_HEAP_SIZE, 64'h0000_0000_0001_0000);
      random_items(120, 5);
      write_register(bfha_pkg::REG_HEAP_BASE, MASK48 - 40);
      write_register(bfha_pkg::REG_HEAP_SIZE, 4096);
      random_items(80, 25);
      write_register(bfha_pkg::REG_HEAP_SIZE, 0);
      random_items(15, 25);
      write_register(bfha_pkg::REG_HEAP_SIZE, 79);
      random_items(10, 25);
      write_register(bfha_pkg::REG_HEAP_SIZE, 80);
      random_items(10, 25);
      write_register(bfha_pkg::REG_HEAP_BASE, 0);
      write_register(bfha_pkg::REG_HEAP_SIZE, 64'hFFFF_FFFF);
      random_items(100, 20);
      write_register(bfha_pkg::REG_HEAP_SIZE, 2048);
      random_items(60, 25);

      req_if.valid <= 0;
      while (heap_sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (heap_sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
